// ===== design/jfps_pkg.sv =====
// Shared types and constants for the five-point Jacobi stencil unit.
// No dependencies; every other design file but jfps_line_ram uses this package.
package jfps_pkg;

  localparam int MAX_INTERIOR = 2048;
  localparam int LINE_DEPTH   = MAX_INTERIOR + 2;
  localparam int ADDR_W       = $clog2(LINE_DEPTH);
  localparam int CNT_W        = $clog2(LINE_DEPTH + 1);

  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 12;
  localparam int SUM_W   = DATA_W + 3;
  localparam int COEF_W  = 15;
  localparam int PROD_W  = SUM_W + COEF_W;
  localparam int FRAC_W  = 16;
  localparam int QUOT_W  = PROD_W - FRAC_W;

  // 0.2 in Q0.16, truncated
  localparam logic signed [COEF_W-1:0] FIFTH_Q16 = 15'sd13107;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

  // APB register map
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INTERIOR_SIZE = 1'b0;

  typedef struct packed {
    logic [CNT_W-1:0] size;     // effective interior size
    logic [CNT_W-1:0] last;     // index of last grid column/row (size + 1)
    logic             restart;  // register write: restart grid
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] west;
    logic signed [DATA_W-1:0] center;
    logic signed [DATA_W-1:0] east;
    logic signed [DATA_W-1:0] north;
    logic signed [DATA_W-1:0] south;
  } ops_t;

  typedef struct packed {
    logic [SIZE_W-1:0] row;
    logic [SIZE_W-1:0] col;
    logic              done;
  } meta_t;

endpackage

// ===== design/jfps_sample_if.sv =====
// Input stream channel: valid/ready handshake carrying one grid sample.
// Depends on jfps_pkg.
interface jfps_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [jfps_pkg::DATA_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/jfps_result_if.sv =====
// Output stream channel: valid/ready handshake carrying one stencil result.
// Depends on jfps_pkg.
interface jfps_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [jfps_pkg::DATA_W-1:0]  result;
  logic        [jfps_pkg::SIZE_W-1:0]  row_index;
  logic        [jfps_pkg::SIZE_W-1:0]  column_index;
  logic                                grid_done;

  modport source (output valid, output result, output row_index, output column_index,
                  output grid_done, input ready);
  modport sink   (input valid, input result, input row_index, input column_index,
                  input grid_done, output ready);
endinterface

// ===== design/jfps_line_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the two line buffers; no package dependency.
module jfps_line_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2050
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/jfps_cfg.sv =====
// APB register block: interior_size register, size clamping, restart pulse.
// Depends on jfps_pkg.
module jfps_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jfps_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output jfps_pkg::cfg_t                   cfg_o
);
  import jfps_pkg::*;

  // 0 behaves as 1, anything above MAX_INTERIOR saturates to MAX_INTERIOR
  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_INTERIOR)) begin
      r = CNT_W'(MAX_INTERIOR);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]    size_q;
  logic [CNT_W-1:0]     eff_q;
  logic [CNT_W-1:0]     last_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_size;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_size = psel && penable && pwrite && (reg_idx == REG_INTERIOR_SIZE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      eff_q  <= eff_size(SIZE_RESET);
      last_q <= eff_size(SIZE_RESET) + CNT_W'(1);
    end else if (wr_size) begin
      size_q <= pwdata[SIZE_W-1:0];
      eff_q  <= eff_size(pwdata[SIZE_W-1:0]);
      last_q <= eff_size(pwdata[SIZE_W-1:0]) + CNT_W'(1);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_INTERIOR_SIZE) begin
      prdata = 32'(size_q);
    end
  end

  assign cfg_o.size    = eff_q;
  assign cfg_o.last    = last_q;
  assign cfg_o.restart = wr_size;

endmodule

// ===== design/jfps_window.sv =====
// Line buffers, grid position counters and middle-row window.
// Forms the five stencil operands of each accepted sample. Depends on jfps_pkg.
module jfps_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  jfps_pkg::cfg_t                   cfg_i,
  input  logic                             acc_i,
  input  logic signed [jfps_pkg::DATA_W-1:0] sample_i,
  output jfps_pkg::ops_t                   ops_o,
  output jfps_pkg::meta_t                  meta_o,
  output logic                             produce_o
);
  import jfps_pkg::*;

  logic [CNT_W-1:0]         row_q, row_d;
  logic [CNT_W-1:0]         col_q, col_d;
  logic signed [DATA_W-1:0] win_q [3];
  logic signed [DATA_W-1:0] win_d [3];
  logic signed [DATA_W-1:0] hold_q, hold_d;   // middle row, column 0

  logic [DATA_W-1:0]        up_rd, mid_rd;
  logic [ADDR_W-1:0]        up_raddr, mid_raddr, waddr;
  logic [CNT_W:0]           col_p2;
  logic                     first_col, last_col;

  assign first_col = (col_q == '0);
  assign last_col  = (col_q == cfg_i.last);
  assign waddr     = ADDR_W'(col_q);

  // Prefetch: upper row one column ahead, middle row two ahead, wrapping
  // into the start of the next row so column 0 finds its data ready.
  assign col_p2 = {1'b0, col_q} + (CNT_W + 1)'(2);

  always_comb begin
    if (last_col) begin
      up_raddr = '0;
    end else begin
      up_raddr = ADDR_W'(col_q + CNT_W'(1));
    end
    if (col_p2 > {1'b0, cfg_i.last}) begin
      mid_raddr = ADDR_W'(col_p2 - {1'b0, cfg_i.last} - (CNT_W + 1)'(1));
    end else begin
      mid_raddr = ADDR_W'(col_p2);
    end
  end

  always_comb begin
    if (first_col) begin
      win_d[0] = '0;
      win_d[1] = hold_q;
      win_d[2] = mid_rd;
    end else begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = last_col ? '0 : mid_rd;
    end
    hold_d = last_col ? mid_rd : hold_q;

    if (last_col) begin
      col_d = '0;
      row_d = (row_q == cfg_i.last) ? '0 : row_q + CNT_W'(1);
    end else begin
      col_d = col_q + CNT_W'(1);
      row_d = row_q;
    end
  end

  jfps_line_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (acc_i),
    .waddr_i (waddr),
    .wdata_i (win_d[1]),
    .re_i    (acc_i),
    .raddr_i (up_raddr),
    .rdata_o (up_rd)
  );

  jfps_line_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (acc_i),
    .waddr_i (waddr),
    .wdata_i (sample_i),
    .re_i    (acc_i),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
      hold_q   <= '0;
    end else if (cfg_i.restart) begin
      row_q    <= '0;
      col_q    <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (acc_i) begin
      row_q    <= row_d;
      col_q    <= col_d;
      win_q[0] <= win_d[0];
      win_q[1] <= win_d[1];
      win_q[2] <= win_d[2];
      hold_q   <= hold_d;
    end
  end

  assign ops_o.west   = win_d[0];
  assign ops_o.center = win_d[1];
  assign ops_o.east   = win_d[2];
  assign ops_o.north  = up_rd;
  assign ops_o.south  = sample_i;

  assign meta_o.row  = SIZE_W'(row_q - CNT_W'(1));
  assign meta_o.col  = SIZE_W'(col_q);
  assign meta_o.done = (row_q == cfg_i.last) && (col_q == cfg_i.size);

  assign produce_o = (row_q >= CNT_W'(2)) && !first_col && !last_col;

endmodule

// ===== design/jfps_pipe.sv =====
// Arithmetic stage: operand register, then 35-bit sum, multiply by 0.2 and
// floor shift with saturation into the result register. Depends on jfps_pkg.
module jfps_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  logic                   produce_i,
  input  jfps_pkg::ops_t         ops_i,
  input  jfps_pkg::meta_t        meta_i,
  output logic                   ready_o,
  jfps_result_if.source          out_if
);
  import jfps_pkg::*;

  logic a_v_q, o_v_q;
  logic a_free, o_free;

  ops_t                     a_ops_q;
  meta_t                    a_meta_q, o_meta_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [QUOT_W-1:0] quot;
  logic signed [DATA_W-1:0] sat_d, o_res_q;

  assign o_free  = !o_v_q || out_if.ready;
  assign a_free  = !a_v_q || o_free;
  assign ready_o = a_free;

  assign sum_d = SUM_W'(a_ops_q.west) + SUM_W'(a_ops_q.center) + SUM_W'(a_ops_q.east)
               + SUM_W'(a_ops_q.north) + SUM_W'(a_ops_q.south);

  assign prod_d = sum_d * FIFTH_Q16;

  // arithmetic shift floors toward minus infinity
  assign quot = QUOT_W'(prod_d >>> FRAC_W);

  always_comb begin
    if (!quot[QUOT_W-1] && (quot[QUOT_W-2:DATA_W-1] != '0)) begin
      sat_d = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (quot[QUOT_W-1] && (quot[QUOT_W-2:DATA_W-1] != '1)) begin
      sat_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_d = quot[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_free) a_v_q <= acc_i && produce_i;
      if (o_free) o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && acc_i) begin
      a_ops_q  <= ops_i;
      a_meta_q <= meta_i;
    end
    if (o_free) begin
      o_res_q  <= sat_d;
      o_meta_q <= a_meta_q;
    end
  end

  assign out_if.valid        = o_v_q;
  assign out_if.result       = o_res_q;
  assign out_if.row_index    = o_meta_q.row;
  assign out_if.column_index = o_meta_q.col;
  assign out_if.grid_done    = o_meta_q.done;

endmodule

// ===== design/jacobi_five_point_stencil_unit.sv =====
// Top level of the streaming five-point Jacobi stencil unit.
// Depends on jfps_pkg, jfps_sample_if, jfps_result_if, jfps_cfg, jfps_window, jfps_pipe.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------------
//  in_if     | in        | valid/ready        | sample (Q16.16)
//  out_if    | out       | valid/ready        | result, row_index, column_index, grid_done
//  apb       | in        | psel/penable/pready| interior_size at byte address 0
//
// One sample transaction per cycle, sustained while out_if is not stalled. A
// producing sample is caught in the operand register at its accept edge; sum,
// multiply and shift/saturate are combinational into the result register, so
// out_if.valid rises once the result register has loaded its result. Each line
// buffer does one read and one write per transaction, which is what sets the
// one-per-cycle rate. Reset clears counters, window and pipeline valids; line
// buffers are not cleared and need no clearing pass. A stalled out_if fills the
// operand and result registers and then drops in_if.ready; boundary samples leave no entry.
module jacobi_five_point_stencil_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jfps_sample_if.sink                  in_if,
  jfps_result_if.source                out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jfps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import jfps_pkg::*;

  cfg_t  cfg;
  ops_t  ops;
  meta_t meta;
  logic  produce;
  logic  pipe_ready;
  logic  acc;

  // sample transaction completes on this edge
  assign acc         = in_if.valid && pipe_ready;
  assign in_if.ready = pipe_ready;

  jfps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // position tracking, line buffers and the 3-wide middle-row window
  jfps_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .acc_i     (acc),
    .sample_i  (in_if.sample),
    .ops_o     (ops),
    .meta_o    (meta),
    .produce_o (produce)
  );

  // sum, scale by one fifth, saturate, hold for out_if
  jfps_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .produce_i (produce),
    .ops_i     (ops),
    .meta_i    (meta),
    .ready_o   (pipe_ready),
    .out_if    (out_if)
  );

endmodule
